// ===== rtl/core/gti_pkg.sv =====
package gti_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int FRAC_BITS = 16;

    // payload field widths
    localparam int ROW_W = 6;
    localparam int COL_W = 6;
    localparam int VAL_W = 32;
    localparam int CRD_W = 32;
    localparam int STP_W = 31;
    localparam int USE_W = 7;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_R = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_R   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Z   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd5;

    localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    // integer quotient bits, then fraction bits: one divider bit per step
    localparam int QB = $clog2(MAX_DIM);
    localparam int DS = QB + FRAC_BITS;

    // divider state of one axis
    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic          upper;
        logic          remnz;
        logic [31:0]   rem;
        logic [DS-1:0] xs;
        logic [DS-1:0] q;
    } t_axis;

    typedef struct packed {
        logic                    act;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic [VAL_W-1:0]        val;
        t_axis                   ax_r;
        t_axis                   ax_z;
    } t_item;

endpackage

// ===== rtl/core/gti_if.sv =====
interface gti_in_if import gti_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic [ROW_W-1:0]        grid_row;
    logic [COL_W-1:0]        grid_col;
    logic signed [VAL_W-1:0] sample_value;
    logic signed [CRD_W-1:0] r_coord;
    logic signed [CRD_W-1:0] z_coord;

    modport source(output valid, action, grid_row, grid_col, sample_value, r_coord, z_coord,
                   input ready);
    modport sink(input valid, action, grid_row, grid_col, sample_value, r_coord, z_coord,
                 output ready);
endinterface

interface gti_out_if import gti_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] interp_value;
    logic                    outside_grid;

    modport source(output valid, interp_value, outside_grid, input ready);
    modport sink(input valid, interp_value, outside_grid, output ready);
endinterface

// ===== rtl/core/grid_triangle_interpolator_unit.sv =====
// Grid triangle interpolator. Write items (action 0) load one sample of the
// MAX_ROWS x MAX_COLS grid; query items (action 1) return one result each,
// the triangle blend of three neighboring samples, or 0 with outside_grid set.
// One item is accepted every cycle unless the result output stalls; a query
// result passes the input register, 11 divider stages of two restoring-division
// bits each, address, grid read, select, multiply, sum and output register. The
// grid is held in four parity banks so all four cell corners read together.
// Writes take effect in order with queries. Configuration is to be written via the
// cfg port only while no item is in flight (unchecked); the grid has no reset contents.
module grid_triangle_interpolator_unit import gti_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gti_in_if.sink               i_in,
    gti_out_if.source            o_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int SPS  = 2;
    localparam int NSTG = (DS + SPS - 1) / SPS;
    localparam int F    = FRAC_BITS;
    localparam int UW   = QB + 8;
    localparam int RB   = $clog2(MAX_ROWS);
    localparam int CB   = $clog2(MAX_COLS);
    localparam int RHB  = (RB > 1) ? RB - 1 : 1;
    localparam int CHB  = (CB > 1) ? CB - 1 : 1;
    localparam int BAW  = RHB + CHB;
    localparam int BD   = 1 << BAW;
    localparam int AW   = F + 38;
    localparam int RW   = AW - F;

    // configuration
    logic signed [31:0] r_org_r, r_org_z;
    logic [STP_W-1:0]   r_step_r, r_step_z;
    logic [USE_W-1:0]   r_cols, r_rows;
    logic [STP_W-1:0]   steff_r, steff_z;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_r  <= '0;
            r_org_z  <= '0;
            r_step_r <= STP_W'(65536);
            r_step_z <= STP_W'(65536);
            r_cols   <= USE_W'(64);
            r_rows   <= USE_W'(64);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ORIGIN_R: r_org_r  <= i_cfg_data;
                CFG_ORIGIN_Z: r_org_z  <= i_cfg_data;
                CFG_STEP_R:   r_step_r <= i_cfg_data[STP_W-1:0];
                CFG_STEP_Z:   r_step_z <= i_cfg_data[STP_W-1:0];
                CFG_COLS:     r_cols   <= i_cfg_data[USE_W-1:0];
                CFG_ROWS:     r_rows   <= i_cfg_data[USE_W-1:0];
                default: ;
            endcase
        end
    end

    // a zero step acts as one
    assign steff_r = (r_step_r == '0) ? STP_W'(1) : r_step_r;
    assign steff_z = (r_step_z == '0) ? STP_W'(1) : r_step_z;

    logic en;
    logic r_ov;
    assign en = !r_ov || o_res.ready;
    assign i_in.ready = en;

    function automatic t_axis axis_init(input logic signed [CRD_W-1:0] p,
                                        input logic signed [31:0] org,
                                        input logic [STP_W-1:0] st);
        t_axis a;
        logic signed [32:0] d;
        d = {p[CRD_W-1], p} - {org[31], org};
        a.neg   = d[32];
        a.rem   = 32'(d[31:0] >> QB);
        a.ovf   = a.rem >= {1'b0, st};
        a.xs    = {d[QB-1:0], {F{1'b0}}};
        a.q     = '0;
        a.upper = 1'b0;
        a.remnz = 1'b0;
        return a;
    endfunction

    function automatic t_axis div_step(input t_axis a, input logic [STP_W-1:0] st,
                                       input logic cap);
        t_axis o;
        logic [32:0] t;
        o = a;
        t = {a.rem, a.xs[DS-1]};
        o.xs = a.xs << 1;
        if (t >= {2'b0, st}) begin
            o.rem = 32'(t - {2'b0, st});
            o.q   = {a.q[DS-2:0], 1'b1};
        end else begin
            o.rem = t[31:0];
            o.q   = {a.q[DS-2:0], 1'b0};
        end
        // remainder of the integer part is final here
        if (cap) begin
            o.upper = {o.rem, 1'b0} > {2'b0, st};
            o.remnz = o.rem != '0;
        end
        return o;
    endfunction

    // divider pipeline
    t_item r_stg [0:NSTG];
    t_item n_stg [0:NSTG];
    logic  r_sv  [0:NSTG];

    always_comb begin
        t_item tmp;
        int j;
        n_stg[0].act  = i_in.action;
        n_stg[0].row  = i_in.grid_row;
        n_stg[0].col  = i_in.grid_col;
        n_stg[0].val  = i_in.sample_value;
        n_stg[0].ax_r = axis_init(i_in.r_coord, r_org_r, steff_r);
        n_stg[0].ax_z = axis_init(i_in.z_coord, r_org_z, steff_z);
        for (int k = 1; k <= NSTG; k++) begin
            tmp = r_stg[k-1];
            for (int s = 0; s < SPS; s++) begin
                j = (k - 1) * SPS + s;
                if (j < DS) begin
                    tmp.ax_r = div_step(tmp.ax_r, steff_r, j == QB - 1);
                    tmp.ax_z = div_step(tmp.ax_z, steff_z, j == QB - 1);
                end
            end
            n_stg[k] = tmp;
        end
    end

    // bounds and bank addresses
    logic [QB-1:0]  m_idx, n_idx;
    logic [UW-1:0]  nc, nr, m2, n2;
    logic           out_r, out_z;
    logic [BAW-1:0] raddr [4];
    logic [QB:0]    m1, n1;

    always_comb begin
        m_idx = r_stg[NSTG].ax_r.q[DS-1:F];
        n_idx = r_stg[NSTG].ax_z.q[DS-1:F];
        nc = (UW'(r_cols) > UW'(MAX_COLS)) ? UW'(MAX_COLS) : UW'(r_cols);
        nr = (UW'(r_rows) > UW'(MAX_ROWS)) ? UW'(MAX_ROWS) : UW'(r_rows);
        m2 = UW'(m_idx) + UW'(2);
        n2 = UW'(n_idx) + UW'(2);
        out_r = r_stg[NSTG].ax_r.neg || r_stg[NSTG].ax_r.ovf || (nc < UW'(2)) ||
                (m2 > nc) || ((m2 == nc) && r_stg[NSTG].ax_r.remnz);
        out_z = r_stg[NSTG].ax_z.neg || r_stg[NSTG].ax_z.ovf || (nr < UW'(2)) ||
                (n2 > nr) || ((n2 == nr) && r_stg[NSTG].ax_z.remnz);
        m1 = (QB+1)'(m_idx) + (QB+1)'(1);
        n1 = (QB+1)'(n_idx) + (QB+1)'(1);
        for (int b = 0; b < 4; b++) begin
            // pick whichever of n, n+1 (m, m+1) has this bank's parity
            raddr[b] = {RHB'(((n_idx[0] == b[1]) ? (QB+1)'(n_idx) : n1) >> 1),
                        CHB'(((m_idx[0] == b[0]) ? (QB+1)'(m_idx) : m1) >> 1)};
        end
    end

    logic           r_av, r_a_act, r_a_wen, r_a_out, r_a_n0, r_a_m0, r_a_ur, r_a_uz;
    logic [1:0]     r_a_wbank;
    logic [BAW-1:0] r_a_waddr;
    logic [31:0]    r_a_wdata;
    logic [BAW-1:0] r_a_raddr [4];
    logic [F-1:0]   r_a_u, r_a_v;

    // grid memory and read stage
    logic [31:0]    r_mem [4][BD];
    logic [31:0]    r_rd [4];
    logic           r_mv, r_m_out, r_m_n0, r_m_m0, r_m_ur, r_m_uz;
    logic [F-1:0]   r_m_u, r_m_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int b = 0; b < 4; b++) begin
                if (r_av && r_a_wen && (r_a_wbank == 2'(b))) begin
                    r_mem[b][r_a_waddr] <= r_a_wdata;
                end
                r_rd[b] <= r_mem[b][r_a_raddr[b]];
            end
        end
    end

    // select stage
    logic signed [31:0]    v00, v01, v10, v11;
    logic signed [31:0]    n_a;
    logic signed [32:0]    n_b, n_c;
    logic signed [F+1:0]   n_uq;
    logic                  r_dv, r_d_out;
    logic signed [31:0]    r_d_a;
    logic signed [32:0]    r_d_b, r_d_c;
    logic signed [F+1:0]   r_d_uq;
    logic signed [F:0]     r_d_vq;

    always_comb begin
        v00 = r_rd[{r_m_n0, r_m_m0}];
        v01 = r_rd[{r_m_n0, !r_m_m0}];
        v10 = r_rd[{!r_m_n0, r_m_m0}];
        v11 = r_rd[{!r_m_n0, !r_m_m0}];
        n_uq = $signed({2'b00, r_m_u});
        if (r_m_ur && r_m_uz) begin
            n_a  = v01;
            n_b  = 33'(v11) - 33'(v10);
            n_c  = 33'(v11) - 33'(v01);
            n_uq = $signed({2'b00, r_m_u}) - $signed((F+2)'(1) << F);
        end else if (r_m_ur) begin
            n_a = v00;
            n_b = 33'(v01) - 33'(v00);
            n_c = 33'(v11) - 33'(v01);
        end else if (r_m_uz) begin
            n_a = v00;
            n_b = 33'(v11) - 33'(v10);
            n_c = 33'(v10) - 33'(v00);
        end else begin
            n_a = v00;
            n_b = 33'(v01) - 33'(v00);
            n_c = 33'(v10) - 33'(v00);
        end
    end

    // multiply, sum and saturate
    logic                   r_pv, r_p_out;
    logic signed [31+F:0]   r_pa;
    logic signed [34+F:0]   r_pb;
    logic signed [33+F:0]   r_pc;
    logic                   r_qv, r_q_out;
    logic signed [AW-1:0]   r_acc;
    logic signed [RW-1:0]   res;
    logic signed [31:0]     sat;
    logic signed [31:0]     r_o_val;
    logic                   r_o_out;

    always_comb begin
        res = RW'(r_acc >>> F);
        if (res[RW-1:31] == '0 || res[RW-1:31] == '1) begin
            sat = res[31:0];
        end else if (res[RW-1]) begin
            sat = 32'sh8000_0000;
        end else begin
            sat = 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NSTG; k++) r_sv[k] <= 1'b0;
            r_av <= 1'b0;
            r_mv <= 1'b0;
            r_dv <= 1'b0;
            r_pv <= 1'b0;
            r_qv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_sv[0] <= i_in.valid;
            for (int k = 1; k <= NSTG; k++) r_sv[k] <= r_sv[k-1];
            r_av <= r_sv[NSTG];
            // writes drop out after the grid stage
            r_mv <= r_av && r_a_act;
            r_dv <= r_mv;
            r_pv <= r_dv;
            r_qv <= r_pv;
            r_ov <= r_qv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= NSTG; k++) r_stg[k] <= n_stg[k];

            r_a_act   <= r_stg[NSTG].act;
            r_a_wen   <= !r_stg[NSTG].act && (32'(r_stg[NSTG].row) < MAX_ROWS) &&
                         (32'(r_stg[NSTG].col) < MAX_COLS);
            r_a_wbank <= {r_stg[NSTG].row[0], r_stg[NSTG].col[0]};
            r_a_waddr <= {RHB'(r_stg[NSTG].row >> 1), CHB'(r_stg[NSTG].col >> 1)};
            r_a_wdata <= r_stg[NSTG].val;
            for (int b = 0; b < 4; b++) r_a_raddr[b] <= raddr[b];
            r_a_out   <= out_r || out_z;
            r_a_n0    <= n_idx[0];
            r_a_m0    <= m_idx[0];
            r_a_u     <= r_stg[NSTG].ax_r.q[F-1:0];
            r_a_v     <= r_stg[NSTG].ax_z.q[F-1:0];
            r_a_ur    <= r_stg[NSTG].ax_r.upper;
            r_a_uz    <= r_stg[NSTG].ax_z.upper;

            r_m_out <= r_a_out;
            r_m_n0  <= r_a_n0;
            r_m_m0  <= r_a_m0;
            r_m_u   <= r_a_u;
            r_m_v   <= r_a_v;
            r_m_ur  <= r_a_ur;
            r_m_uz  <= r_a_uz;

            r_d_out <= r_m_out;
            r_d_a   <= n_a;
            r_d_b   <= n_b;
            r_d_c   <= n_c;
            r_d_uq  <= n_uq;
            r_d_vq  <= $signed({1'b0, r_m_v});

            r_p_out <= r_d_out;
            r_pa    <= {r_d_a, {F{1'b0}}};
            r_pb    <= r_d_b * r_d_uq;
            r_pc    <= r_d_c * r_d_vq;

            r_q_out <= r_p_out;
            // round to nearest, ties up
            r_acc   <= AW'(r_pa) + AW'(r_pb) + AW'(r_pc) + (AW'(1) <<< (F - 1));

            r_o_out <= r_q_out;
            r_o_val <= r_q_out ? 32'sd0 : sat;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.interp_value = r_o_val;
    assign o_res.outside_grid = r_o_out;

endmodule
